// ===== src/ssbd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssbd_pkg: shared types and constants of the scan stream block deframer
// phase codes, block tags, status codes, the parser state record and the result record
// ----------------------------------------------------------------------------
`default_nettype none

package ssbd_pkg;

   // block tags seen in the tag phase
   localparam logic [7:0] TAG_COLOR_0 = 8'h44;
   localparam logic [7:0] TAG_COLOR_1 = 8'h48;
   localparam logic [7:0] TAG_COLOR_2 = 8'h4C;
   localparam logic [7:0] TAG_JPEG    = 8'h64;
   localparam logic [7:0] TAG_SKIP    = 8'h82;
   localparam logic [7:0] TAG_END     = 8'h80;

   // result status codes
   localparam logic [2:0] ST_HEADER  = 3'd0;
   localparam logic [2:0] ST_PAYLOAD = 3'd1;
   localparam logic [2:0] ST_END     = 3'd2;
   localparam logic [2:0] ST_JPEG    = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;
   localparam logic [2:0] ST_HALTED  = 3'd5;

   typedef enum logic [7:0] {
      PH_TAG       = 8'b0000_0001,
      PH_INFO_LO   = 8'b0000_0010,
      PH_INFO_HI   = 8'b0000_0100,
      PH_INFO_SKIP = 8'b0000_1000,
      PH_PAY_LO    = 8'b0001_0000,
      PH_PAY_HI    = 8'b0010_0000,
      PH_PAYLOAD   = 8'b0100_0000,
      PH_HALTED    = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  current_channel;
      logic        color_block;
      logic [7:0]  low_length_byte;
      logic [15:0] info_left;
      logic [15:0] payload_left;
   } state_type;

   typedef struct packed {
      logic [2:0] status;
      logic [1:0] channel;
      logic [7:0] payload;
   } result_type;

endpackage

`default_nettype wire

// ===== src/scan_stream_block_deframer_core.sv =====
// the result beat of an accepted byte is registered in the response register
// throughput: one byte per cycle unless the sink stalls a held beat, set by the single parser state register update
// the response register is the only buffer; input stalls only while it is full
// and the sink stalls it
// reset: synchronous, active high; parser back to expecting a tag, no beat held
// ----------------------------------------------------------------------------
// scan_stream_block_deframer_core: scanner data stream block deframer
// splits the raw byte stream into colour, skip and end blocks, halting on an end, jpeg or unknown tag, and passes
// colour payload bytes out tagged with their channel
// ----------------------------------------------------------------------------
`default_nettype none

module scan_stream_block_deframer_core (
   input  wire logic       clock,
   input  wire logic       reset,
   // input stream
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   // result stream
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_status,
   output logic [1:0]      rsp_channel,
   output logic [7:0]      rsp_payload
);
   import ssbd_pkg::*;

   // parser state
   state_type  state_ff;
   state_type  state_in;

   // result register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   result_type step_result;

   logic       req_take;

   // a held beat only blocks the input while the sink refuses it
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   ssbd_step u_step (
      .cur_state  (state_ff),
      .data_byte  (req_data_byte),
      .next_state (state_in),
      .result     (step_result)
   );

   // the register refills whenever a byte comes in; else it drains once taken
   assign rsp_valid_in = req_take | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase           <= PH_TAG;
         state_ff.current_channel <= 2'd0;
         state_ff.color_block     <= 1'b0;
         state_ff.low_length_byte <= 8'd0;
         state_ff.info_left       <= 16'd0;
         state_ff.payload_left    <= 16'd0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   // result payload needs no reset, guarded by the valid flag
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_ff.status;
   assign rsp_channel = rsp_ff.channel;
   assign rsp_payload = rsp_ff.payload;

`ifndef SYNTHESIS
   // once halted, the parser stays halted until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_HALTED |=> state_ff.phase == PH_HALTED)
      else $error("parser left the halted phase");

   // a byte taken while halted gives a halted beat next cycle
   a_halted_beat: assert property (@(posedge clock) disable iff (reset)
      req_take && state_ff.phase == PH_HALTED |=>
         rsp_valid && rsp_status == ST_HALTED)
      else $error("halted parser gave a non-halted beat");

   // channel and data are zero on every beat that is not payload
   a_non_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_PAYLOAD |-> rsp_channel == 2'd0 && rsp_payload == 8'd0)
      else $error("non-payload beat carries channel or data");

   // every accepted byte produces exactly one beat in the next cycle
   a_beat_per_byte: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("accepted byte produced no beat");
`endif

endmodule

`default_nettype wire

// ===== src/ssbd_step.sv =====
// ----------------------------------------------------------------------------
// ssbd_step: per-beat parser decision
// next parser state and result for one stream byte, purely combinational
// ----------------------------------------------------------------------------
`default_nettype none

module ssbd_step (
   input  wire ssbd_pkg::state_type  cur_state,
   input  wire logic [7:0]           data_byte,
   output ssbd_pkg::state_type       next_state,
   output ssbd_pkg::result_type      result
);
   import ssbd_pkg::*;

   logic [15:0] length_word;
   logic [15:0] info_dec;
   logic [15:0] payload_dec;
   phase_type   after_info;

   assign length_word = {data_byte, cur_state.low_length_byte};
   assign info_dec    = cur_state.info_left - 16'd1;
   assign payload_dec = cur_state.payload_left - 16'd1;
   assign after_info  = cur_state.color_block ? PH_PAY_LO : PH_TAG;

   always_comb begin
      next_state     = cur_state;
      result.status  = ST_HEADER;
      result.channel = 2'd0;
      result.payload = 8'd0;
      unique case (cur_state.phase)
         PH_TAG: begin
            unique case (data_byte)
               TAG_COLOR_0, TAG_COLOR_1, TAG_COLOR_2: begin
                  // channel is tag bits 3:2 less one
                  next_state.current_channel = data_byte[3:2] - 2'd1;
                  next_state.color_block     = 1'b1;
                  next_state.phase           = PH_INFO_LO;
               end
               TAG_SKIP: begin
                  next_state.color_block = 1'b0;
                  next_state.phase       = PH_INFO_LO;
               end
               TAG_END: begin
                  next_state.phase = PH_HALTED;
                  result.status    = ST_END;
               end
               TAG_JPEG: begin
                  next_state.phase = PH_HALTED;
                  result.status    = ST_JPEG;
               end
               default: begin
                  next_state.phase = PH_HALTED;
                  result.status    = ST_UNKNOWN;
               end
            endcase
         end
         PH_INFO_LO: begin
            next_state.low_length_byte = data_byte;
            next_state.phase           = PH_INFO_HI;
         end
         PH_INFO_HI: begin
            next_state.info_left = length_word;
            next_state.phase     = (length_word == 16'd0) ? after_info : PH_INFO_SKIP;
         end
         PH_INFO_SKIP: begin
            next_state.info_left = info_dec;
            if (info_dec == 16'd0) begin
               next_state.phase = after_info;
            end
         end
         PH_PAY_LO: begin
            next_state.low_length_byte = data_byte;
            next_state.phase           = PH_PAY_HI;
         end
         PH_PAY_HI: begin
            next_state.payload_left = length_word;
            next_state.color_block  = 1'b0;
            next_state.phase        = (length_word == 16'd0) ? PH_TAG : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            result.status           = ST_PAYLOAD;
            result.channel          = cur_state.current_channel;
            result.payload          = data_byte;
            next_state.payload_left = payload_dec;
            if (payload_dec == 16'd0) begin
               next_state.phase = PH_TAG;
            end
         end
         PH_HALTED: begin
            result.status = ST_HALTED;
         end
         default: begin
            result.status = ST_HALTED;
         end
      endcase
   end

endmodule

`default_nettype wire
